>>> rtl/baseline_moving_average_landing_detect_macros.svh
// assertion macros shared by the landing detector rtl
// needs clk and rst_n in scope at the point of use
`ifndef BASELINE_MOVING_AVERAGE_LANDING_DETECT_MACROS_SVH
`define BASELINE_MOVING_AVERAGE_LANDING_DETECT_MACROS_SVH

// combinational property checked at every rising clock edge out of reset
`define BMALD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent this cycle implies consequent on the next cycle
`define BMALD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bmald_pkg.sv
// shared types, constants and the divide-by-window helper for the landing detector
// no dependencies
package bmald_pkg;

  localparam int DATA_W = 16;
  localparam int WINDOW = 15;
  localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 16'sd20000;

  // count runs 1 .. WINDOW+1
  localparam int CNT_W = $clog2(WINDOW + 2);
  // holds WINDOW full-scale samples without overflow
  localparam int SUM_W = DATA_W + $clog2(WINDOW);

  // reciprocal for truncating division of a SUM_W magnitude by WINDOW
  localparam int RECIP_SHIFT = SUM_W - 1 + $clog2(WINDOW);
  localparam int RECIP_W = RECIP_SHIFT - $clog2(WINDOW) + 1;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic signed [SUM_W-1:0] AVG_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] AVG_MIN = -SUM_W'(32768);

  typedef struct packed {
    logic signed [DATA_W-1:0] average_value;
    logic                     average_ready;
    logic                     landed;
  } bmald_result_t;

  // signed division by WINDOW, truncated toward zero
  function automatic logic signed [SUM_W-1:0] div_window(input logic signed [SUM_W-1:0] num);
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  q;
    mag  = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    q    = SUM_W'(prod >> RECIP_SHIFT);
    return num[SUM_W-1] ? $signed(-q) : $signed(q);
  endfunction

  // clamp a wide signed value to the 16-bit range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > AVG_MAX) begin
      r = 16'sh7fff;
    end else if (v < AVG_MIN) begin
      r = 16'sh8000;
    end else begin
      r = DATA_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_data(input logic signed [DATA_W-1:0] v);
    return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

>>> rtl/bmald_core.sv
// baseline sum, moving average state and threshold compare for one sample
// depends on bmald_pkg and the shared assertion macros
`include "baseline_moving_average_landing_detect_macros.svh"

module bmald_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  logic signed [bmald_pkg::DATA_W-1:0]    sample,
  input  logic signed [bmald_pkg::DATA_W-1:0]    threshold,
  output bmald_pkg::bmald_result_t               result
);

  logic [bmald_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [bmald_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [bmald_pkg::DATA_W-1:0] avg_r, avg_nxt;

  logic signed [bmald_pkg::SUM_W-1:0]  sample_ext;
  logic signed [bmald_pkg::SUM_W-1:0]  avg_ext;
  logic signed [bmald_pkg::SUM_W-1:0]  sum_add;
  logic signed [bmald_pkg::SUM_W-1:0]  upd_wide;
  logic signed [bmald_pkg::DATA_W-1:0] base_avg;
  logic signed [bmald_pkg::DATA_W-1:0] upd_avg;
  logic signed [bmald_pkg::DATA_W-1:0] avg_new;
  logic                                in_base;
  logic                                at_window;
  logic                                landed;

  localparam logic [bmald_pkg::CNT_W-1:0] CNT_WIN = bmald_pkg::CNT_W'(bmald_pkg::WINDOW);
  localparam logic [bmald_pkg::CNT_W-1:0] CNT_ONE = bmald_pkg::CNT_W'(1);

  assign sample_ext = bmald_pkg::sext_data(sample);
  assign avg_ext    = bmald_pkg::sext_data(avg_r);
  assign sum_add    = sum_r + sample_ext;
  assign base_avg   = bmald_pkg::sat_data(bmald_pkg::div_window(sum_add));
  assign upd_wide   = avg_ext - bmald_pkg::div_window(avg_ext)
                    + bmald_pkg::div_window(sample_ext);
  assign upd_avg    = bmald_pkg::sat_data(upd_wide);

  assign in_base   = (cnt_r < CNT_WIN);
  assign at_window = (cnt_r == CNT_WIN);

  always_comb begin
    if (in_base) begin
      avg_new = avg_r;
    end else if (at_window) begin
      avg_new = base_avg;
    end else begin
      avg_new = upd_avg;
    end
    landed = (avg_new > threshold);

    result.average_value = avg_new;
    result.average_ready = !in_base;
    result.landed        = landed;

    if (landed) begin
      cnt_nxt = CNT_ONE;
      sum_nxt = '0;
      avg_nxt = '0;
    end else begin
      cnt_nxt = (cnt_r <= CNT_WIN) ? cnt_r + CNT_ONE : cnt_r;
      sum_nxt = (cnt_r <= CNT_WIN) ? sum_add : sum_r;
      avg_nxt = avg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_ONE;
      sum_r <= '0;
      avg_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      avg_r <= avg_nxt;
    end
  end

  `BMALD_ASSERT(a_cnt_range, (cnt_r != '0) && (cnt_r <= CNT_WIN + CNT_ONE), "sample count out of range")
  `BMALD_ASSERT(a_sum_clear, (cnt_r != CNT_ONE) || (sum_r == '0), "sum not clear at first sample")
  `BMALD_ASSERT(a_avg_base, (cnt_r > CNT_WIN) || (avg_r == '0), "average set during baseline")
  `BMALD_ASSERT_NEXT(a_land_restart, step && landed, cnt_r == CNT_ONE, "count not restarted after landing")

endmodule

>>> rtl/baseline_moving_average_landing_detect.sv
// Landing detector: each accepted sample updates a baseline sum or moving
// average and compares it with a programmable threshold. Accepts one sample
// transaction per clock unless the output side stalls, and returns exactly
// one result transaction for it through the input register and the result
// register, with a single pass through the update logic between them. The
// first 15 samples after reset or after a landing build the baseline (the
// first 14 show average 0, ready low); the 15th sets the average to sum/15,
// later samples blend in at 1/15 weight. Landed is raised when the average
// is strictly above the threshold, and the count, sum and average then
// start over. Threshold resets to 20000 and should be written only while idle.
// depends on bmald_pkg, bmald_core and the shared assertion macros

module baseline_moving_average_landing_detect (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write
  input  logic                                 cfg_wr_en,
  input  logic signed [bmald_pkg::DATA_W-1:0]  cfg_wr_data,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [bmald_pkg::DATA_W-1:0]  in_accel_sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bmald_pkg::DATA_W-1:0]  out_average_value,
  output logic                                 out_average_ready,
  output logic                                 out_landed
);

  // threshold register
  logic signed [bmald_pkg::DATA_W-1:0] thr_r;

  // input stage
  logic                                in_valid_r;
  logic signed [bmald_pkg::DATA_W-1:0] sample_r;

  // result stage
  logic                                out_valid_r;
  bmald_pkg::bmald_result_t            result_r;
  bmald_pkg::bmald_result_t            result_nxt;

  logic out_adv;  // result register can take a new transaction
  logic step;     // input stage moves into the result register

  assign out_adv  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_adv;
  // input register refills when empty or draining this cycle
  assign in_stall = in_valid_r && !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= bmald_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sample_r <= in_accel_sample;
    end
  end

  // state update and compare for the sample in the input register
  bmald_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sample    (sample_r),
    .threshold (thr_r),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_value = result_r.average_value;
  assign out_average_ready = result_r.average_ready;
  assign out_landed        = result_r.landed;

endmodule

>>> tb/baseline_moving_average_landing_detect_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for baseline_moving_average_landing_detect
// depends on bmald_pkg and the landing detector rtl, nothing else

module baseline_moving_average_landing_detect_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 120;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic signed [bmald_pkg::DATA_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic signed [bmald_pkg::DATA_W-1:0] in_accel_sample;
  logic out_valid;
  logic out_stall;
  logic signed [bmald_pkg::DATA_W-1:0] out_average_value;
  logic out_average_ready;
  logic out_landed;

  baseline_moving_average_landing_detect uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_accel_sample(in_accel_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_average_value(out_average_value),
    .out_average_ready(out_average_ready),
    .out_landed(out_landed)
  );

  // samples waiting to be offered, and results owed by the block in order
  logic signed [bmald_pkg::DATA_W-1:0] sample_queue[$];
  bmald_pkg::bmald_result_t result_due[$];

  // shadow of the detector state and its threshold register
  int sample_num;
  int base_sum;
  logic signed [bmald_pkg::DATA_W-1:0] avg_now;
  logic signed [bmald_pkg::DATA_W-1:0] land_thresh;

  int err_cnt;
  int cycle_cnt;
  bit idle_on;
  bit sample_taken;
  int src_gap;
  int dst_gap;
  int hold_left;
  int holds_asked;
  int holds_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp to the signed 16-bit range
  function automatic logic signed [bmald_pkg::DATA_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return bmald_pkg::DATA_W'(v);
  endfunction

  // next result of the landing detector for one accepted sample
  function automatic bmald_pkg::bmald_result_t landing_predict(
    input logic signed [bmald_pkg::DATA_W-1:0] smp
  );
    bmald_pkg::bmald_result_t res;
    int a;
    res.average_ready = 1'b0;
    res.landed = 1'b0;
    if (sample_num < bmald_pkg::WINDOW) begin
      base_sum += int'(smp);
    end else if (sample_num == bmald_pkg::WINDOW) begin
      // baseline complete: sum over the window, int division truncates toward zero
      base_sum += int'(smp);
      avg_now = clip16(base_sum / bmald_pkg::WINDOW);
      res.average_ready = 1'b1;
    end else begin
      a = int'(avg_now);
      a = a - a / bmald_pkg::WINDOW + int'(smp) / bmald_pkg::WINDOW;
      avg_now = clip16(a);
      res.average_ready = 1'b1;
    end
    res.average_value = avg_now;
    // the compare also runs during baseline, where the held average is zero
    if (avg_now > land_thresh) begin
      res.landed = 1'b1;
      sample_num = 1;
      base_sum = 0;
      avg_now = '0;
    end else if (sample_num <= bmald_pkg::WINDOW) begin
      sample_num++;
    end
    return res;
  endfunction

  // sampling side: check result transactions, then predict for accepted samples
  always @(posedge clk) begin
    bmald_pkg::bmald_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (result_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result avg=%0d ready=%0b landed=%0b", $time,
                 out_average_value, out_average_ready, out_landed);
      end else begin
        exp_r = result_due.pop_front();
        if (out_average_value !== exp_r.average_value) begin
          err_cnt++;
          $display("%0t: average_value expected %0d actual %0d", $time,
                   exp_r.average_value, out_average_value);
        end
        if (out_average_ready !== exp_r.average_ready) begin
          err_cnt++;
          $display("%0t: average_ready expected %0b actual %0b", $time,
                   exp_r.average_ready, out_average_ready);
        end
        if (out_landed !== exp_r.landed) begin
          err_cnt++;
          $display("%0t: landed expected %0b actual %0b", $time,
                   exp_r.landed, out_landed);
        end
      end
    end
    sample_taken = rst_n && in_valid && !in_stall;
    if (sample_taken) begin
      result_due.push_back(landing_predict(in_accel_sample));
    end
  end

  // sample driver: new transaction only once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_accel_sample <= '0;
    end else if (!in_valid || sample_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        // idle burst
        src_gap = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_accel_sample <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall bursts plus the occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < holds_asked) begin
      // long hold so the block backs up and stalls its input
      holds_done++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (dst_gap > 0) begin
      dst_gap--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      dst_gap = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("baseline_moving_average_landing_detect_tb failed");
      $finish;
    end
  end

  // wait until every sample is taken and every result has come back
  task automatic drain();
    while (sample_queue.size() > 0 || in_valid || result_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // threshold is only written while the block is idle
  task automatic write_threshold(input logic signed [bmald_pkg::DATA_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    land_thresh = v;
  endtask

  // flight profile: segments settling around a level with noise, plus stray samples
  task automatic queue_flight(input int count);
    int level;
    int amp;
    int seg_len;
    int noise;
    int pushed;
    pushed = 0;
    while (pushed < count) begin
      seg_len = $urandom_range(5, 60);
      if ($urandom_range(0, 1) == 0) begin
        // near the threshold so landings come and go
        level = int'(land_thresh) + int'($urandom_range(0, 8000)) - 4000;
      end else begin
        level = int'(signed'(bmald_pkg::DATA_W'($urandom_range(0, 65535))));
      end
      case ($urandom_range(0, 3))
        0: amp = 0;
        1: amp = 50;
        2: amp = 2000;
        default: amp = 16000;
      endcase
      for (int k = 0; k < seg_len && pushed < count; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          sample_queue.push_back(bmald_pkg::DATA_W'($urandom_range(0, 65535)));
        end else begin
          noise = int'($urandom_range(0, 2 * amp)) - amp;
          sample_queue.push_back(clip16(level + noise));
        end
        pushed++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_accel_sample = '0;
    out_stall = 1'b0;
    err_cnt = 0;
    cycle_cnt = 0;
    idle_on = 1'b1;
    src_gap = 0;
    dst_gap = 0;
    hold_left = 0;
    holds_asked = 0;
    holds_done = 0;
    sample_taken = 1'b0;
    sample_num = 1;
    base_sum = 0;
    avg_now = '0;
    land_thresh = bmald_pkg::THRESHOLD_RESET;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold: full-scale positive baseline lands on its last sample
    repeat (bmald_pkg::WINDOW) sample_queue.push_back(16'sh7fff);
    drain();

    // most negative threshold: the held zero average lands on every baseline tick
    write_threshold(16'sh8000);
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'sh7fff);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'shffff);
    drain();

    // most positive threshold: a short mix of extreme samples stays in the baseline, never lands
    write_threshold(16'sh7fff);
    sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh0001);
    sample_queue.push_back(16'sh7fff);
    sample_queue.push_back(16'sh0000);
    drain();

    // random flights across several thresholds
    write_threshold(16'sd1000);
    queue_flight(300);
    drain();

    write_threshold(16'sh7fff);
    queue_flight(200);
    drain();

    write_threshold(16'sh8000);
    queue_flight(40);
    drain();

    // zero threshold, with one long hold-off while the sender keeps offering
    write_threshold(16'sd0);
    queue_flight(300);
    repeat (30) @(posedge clk);
    holds_asked++;
    drain();

    write_threshold(bmald_pkg::DATA_W'($urandom_range(0, 30000)));
    queue_flight(300);
    drain();

    // last part back at the reset level, no idling on either side
    write_threshold(bmald_pkg::THRESHOLD_RESET);
    idle_on = 1'b0;
    queue_flight(260);
    drain();

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && result_due.size() == 0) begin
      $display("baseline_moving_average_landing_detect_tb passed");
    end else begin
      $display("baseline_moving_average_landing_detect_tb failed");
    end
    $finish;
  end

endmodule
